/* rtl/sbt_pkg.sv */
// shared types and constants for the seen beacon table
package sbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 10;
    localparam logic [31:0] MAX_AGE_RESET = 32'd30000;

    localparam int BODY_W  = 32;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 4;
    localparam int AVG_W   = 8;
    localparam int ID_W    = 8;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_MAX_AGE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

/* rtl/seen_beacon_table_top.sv */
// seen beacon table: entry scan, aging query and id averaging
//
// input channel: i_in_valid / o_in_stall carry one beat of cmd, body, time_ms.
// a record beat (cmd 0) walks the entries from 0 upward, stops on the first
// body match, else keeps the first entry holding the smallest stamp, and
// writes body and stamp there; the result gives the entry index.
// a query beat (cmd 1) ages every entry against time_ms and max_age, clears
// the aged ones, counts the rest and divides their id byte sum by the count.
// output channel: o_out_valid / i_out_stall carry slot_index, valid_count,
// avg_id; one result beat per input beat.
// sequence: the walk reads one entry at a time (one entry memory port, read data
// registered), then a record write, or for a query a shift-subtract divider
// over the 8+clog2(N+1)-bit id sum (skipped if nothing is valid), then the
// output register is loaded; the block passes through idle before the next
// beat is taken.
// the block takes one item at a time; o_in_stall is high from acceptance
// until the result sits in the output register. a stalled result holds, and
// the next item is accepted while it waits.
// reset clears every entry (per-entry valid bits) and sets max_age to 30000.
// max_age lies at byte address 0 of the apb port; pready is always high.
module seen_beacon_table_top #(
    parameter int TABLE_ENTRIES = sbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [sbt_pkg::BODY_W-1:0]   i_body,
    input  logic [sbt_pkg::TIME_W-1:0]   i_time_ms,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sbt_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [sbt_pkg::COUNT_W-1:0]  o_valid_count,
    output logic [sbt_pkg::AVG_W-1:0]    o_avg_id,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sbt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = ID_W + CW;
    localparam int BW = $clog2(SW + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // entry memory
    logic [BODY_W-1:0] mem_body  [TABLE_ENTRIES];
    logic [TIME_W-1:0] mem_stamp [TABLE_ENTRIES];
    logic              mem_we;

    t_state                 r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_vld, n_vld;
    logic                   r_cmd, n_cmd;
    logic [BODY_W-1:0]      r_body, n_body;
    logic [TIME_W-1:0]      r_time, n_time;
    logic [IW-1:0]          r_idx, n_idx;
    logic [IW-1:0]          r_victim, n_victim;
    logic [TIME_W-1:0]      r_smallest, n_smallest;
    logic [SW-1:0]          r_sum, n_sum;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_rem, n_rem;
    logic [BW-1:0]          r_bit, n_bit;
    logic [31:0]            r_max_age, n_max_age;
    logic                   r_out_vld, n_out_vld;
    logic [SLOT_W-1:0]      r_out_slot, n_out_slot;
    logic [COUNT_W-1:0]     r_out_count, n_out_count;
    logic [AVG_W-1:0]       r_out_avg, n_out_avg;

    logic [BODY_W-1:0]      r_rd_body;
    logic [TIME_W-1:0]      r_rd_stamp;
    logic                   r_rd_vld;

    logic [BODY_W-1:0]      eff_body;
    logic [TIME_W-1:0]      eff_stamp;
    logic [TIME_W-1:0]      age;
    logic [CW:0]            rem_sh;
    logic [CW:0]            rem_diff;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_AGE);
    assign prdata = (paddr[2] == REG_MAX_AGE) ? r_max_age : 32'd0;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_slot_index  = r_out_slot;
    assign o_valid_count = r_out_count;
    assign o_avg_id      = r_out_avg;

    // entries without a valid bit read as zero
    assign eff_body  = r_rd_vld ? r_rd_body  : '0;
    assign eff_stamp = r_rd_vld ? r_rd_stamp : '0;
    assign age       = r_time - eff_stamp;
    assign rem_sh    = {r_rem, r_sum[SW-1]};
    assign rem_diff  = rem_sh - {1'b0, r_count};

    assign mem_we = (r_state == ST_WRITE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_body[r_victim]  <= r_body;
            mem_stamp[r_victim] <= r_time;
        end
        r_rd_body  <= mem_body[r_idx];
        r_rd_stamp <= mem_stamp[r_idx];
        r_rd_vld   <= r_vld[r_idx];
    end

    always_comb begin
        n_state     = r_state;
        n_vld       = r_vld;
        n_cmd       = r_cmd;
        n_body      = r_body;
        n_time      = r_time;
        n_idx       = r_idx;
        n_victim    = r_victim;
        n_smallest  = r_smallest;
        n_sum       = r_sum;
        n_count     = r_count;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_max_age   = cfg_wr ? pwdata : r_max_age;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out_slot  = r_out_slot;
        n_out_count = r_out_count;
        n_out_avg   = r_out_avg;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd      = i_cmd;
                    n_body     = i_body;
                    n_time     = i_time_ms;
                    n_idx      = '0;
                    n_victim   = '0;
                    n_smallest = '1;
                    n_sum      = '0;
                    n_count    = '0;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_cmd == CMD_RECORD) begin
                    if (eff_body == r_body) begin
                        n_victim = r_idx;
                        n_state  = ST_WRITE;
                    end else begin
                        if (eff_stamp < r_smallest) begin
                            n_smallest = eff_stamp;
                            n_victim   = r_idx;
                        end
                        if (r_idx == LAST_IDX) begin
                            n_state = ST_WRITE;
                        end else begin
                            n_idx   = IW'(r_idx + 1'b1);
                            n_state = ST_READ;
                        end
                    end
                end else begin
                    if (age > r_max_age) begin
                        n_vld[r_idx] = 1'b0;
                    end else begin
                        n_sum   = SW'(r_sum + SW'(eff_body[ID_W-1:0]));
                        n_count = CW'(r_count + 1'b1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_rem   = '0;
                        n_bit   = BW'(SW);
                        n_state = ST_DIV;
                    end else begin
                        n_idx   = IW'(r_idx + 1'b1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_WRITE: begin
                n_vld[r_victim] = 1'b1;
                n_sum           = '0;
                n_count         = '0;
                n_state         = ST_DONE;
            end
            ST_DIV: begin
                // restoring divide, quotient shifts into r_sum
                if (r_count == '0) begin
                    n_sum   = '0;
                    n_state = ST_DONE;
                end else begin
                    if (!rem_diff[CW]) begin
                        n_rem = rem_diff[CW-1:0];
                        n_sum = {r_sum[SW-2:0], 1'b1};
                    end else begin
                        n_rem = rem_sh[CW-1:0];
                        n_sum = {r_sum[SW-2:0], 1'b0};
                    end
                    n_bit = BW'(r_bit - 1'b1);
                    if (r_bit == BW'(1)) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld   = 1'b1;
                    n_out_slot  = (r_cmd == CMD_RECORD) ? SLOT_W'(r_victim) : '0;
                    n_out_count = COUNT_W'(r_count);
                    n_out_avg   = AVG_W'(r_sum);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vld     <= '0;
            r_max_age <= MAX_AGE_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vld     <= n_vld;
            r_max_age <= n_max_age;
            r_out_vld <= n_out_vld;
        end
        r_cmd       <= n_cmd;
        r_body      <= n_body;
        r_time      <= n_time;
        r_idx       <= n_idx;
        r_victim    <= n_victim;
        r_smallest  <= n_smallest;
        r_sum       <= n_sum;
        r_count     <= n_count;
        r_rem       <= n_rem;
        r_bit       <= n_bit;
        r_out_slot  <= n_out_slot;
        r_out_count <= n_out_count;
        r_out_avg   <= n_out_avg;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// testbench for the seen beacon table: entry replacement, aging queries and id averages
module testbench;
    import sbt_pkg::*;

    localparam int ENTRIES       = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 80;
    localparam int BODY_POOL     = 12;

    typedef struct packed {
        logic              cmd;
        logic [BODY_W-1:0] body;
        logic [TIME_W-1:0] time_ms;
    } t_beacon;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
        logic [AVG_W-1:0]   avg;
    } t_reply;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_cmd         = CMD_RECORD;
    logic [BODY_W-1:0]  i_body        = '0;
    logic [TIME_W-1:0]  i_time_ms     = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [SLOT_W-1:0]  o_slot_index;
    logic [COUNT_W-1:0] o_valid_count;
    logic [AVG_W-1:0]   o_avg_id;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    seen_beacon_table_top u_top (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_stall, .i_cmd, .i_body, .i_time_ms,
        .o_out_valid, .i_out_stall, .o_slot_index, .o_valid_count, .o_avg_id,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected copy of the table and the aging limit
    logic [TIME_W-1:0] seen_stamp [ENTRIES];
    logic [BODY_W-1:0] seen_body  [ENTRIES];
    logic [31:0]       age_limit;

    t_beacon beacons_to_send [$];
    t_reply  replies_due [$];

    bit idling_on      = 1'b1;
    int cycle_count    = 0;
    int fault_count    = 0;
    int records_taken  = 0;
    int queries_taken  = 0;
    int replies_seen   = 0;
    int limits_written = 0;

    task automatic report_mismatch(input string what);
        fault_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // updates the expected table with one beat and returns the result it causes
    function automatic t_reply apply_beacon(input t_beacon b);
        t_reply            r;
        logic [TIME_W-1:0] lowest;
        logic [TIME_W-1:0] age;
        int                victim;
        int                count;
        int                id_sum;
        bit                hit;
        r = '0;
        if (b.cmd == CMD_RECORD) begin
            lowest = '1;
            victim = 0;
            hit    = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!hit) begin
                    if (seen_body[i] == b.body) begin
                        victim = i;
                        hit    = 1'b1;
                    end else if (seen_stamp[i] < lowest) begin
                        lowest = seen_stamp[i];
                        victim = i;
                    end
                end
            end
            seen_stamp[victim] = b.time_ms;
            seen_body[victim]  = b.body;
            r.slot = victim[SLOT_W-1:0];
        end else begin
            count  = 0;
            id_sum = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                age = b.time_ms - seen_stamp[i];
                if (age > age_limit) begin
                    seen_stamp[i] = '0;
                    seen_body[i]  = '0;
                end else begin
                    id_sum += seen_body[i][ID_W-1:0];
                    count++;
                end
            end
            r.count = count[COUNT_W-1:0];
            if (count != 0)
                r.avg = AVG_W'(id_sum / count);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, replies_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // input side: feeds pending beacons, holds each until taken
    always @(posedge i_clk) begin : feed
        t_beacon on_wire;
        int      send_gap;
        bit      taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                replies_due.push_back(apply_beacon(on_wire));
                if (on_wire.cmd == CMD_RECORD)
                    records_taken++;
                else
                    queries_taken++;
            end
            if (!i_in_valid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (idling_on && beacons_to_send.size() != 0
                             && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 15) - 1;
                    i_in_valid <= 1'b0;
                end else if (beacons_to_send.size() != 0) begin
                    on_wire = beacons_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd      <= on_wire.cmd;
                    i_body     <= on_wire.body;
                    i_time_ms  <= on_wire.time_ms;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: checks every result beat and stalls in bursts
    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        int     hold_gap;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_gap = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_slot_index, o_valid_count, o_avg_id};
                replies_seen++;
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result slot %0d count %0d avg %0d",
                                              got.slot, got.count, got.avg));
                end else begin
                    want = replies_due.pop_front();
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot_index %0d, expected %0d",
                                                  got.slot, want.slot));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("valid_count %0d, expected %0d",
                                                  got.count, want.count));
                    if (got.avg !== want.avg)
                        report_mismatch($sformatf("avg_id %0d, expected %0d",
                                                  got.avg, want.avg));
                end
            end
            if (hold_gap > 0) begin
                hold_gap--;
                i_out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
                hold_gap = $urandom_range(1, 15) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drained;
        do @(negedge i_clk);
        while (beacons_to_send.size() != 0 || i_in_valid || replies_due.size() != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_MAX_AGE, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!wr && prdata !== value)
            report_mismatch($sformatf("max_age reads %0h, expected %0h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // only called with the block idle
    task automatic set_max_age(input logic [31:0] value);
        wait_drained;
        apb_access(1'b1, value);
        age_limit = value;
        limits_written++;
        apb_access(1'b0, value);
    endtask

    task automatic push_beacon(input logic cmd, input logic [31:0] body, input logic [31:0] ms);
        beacons_to_send.push_back('{cmd, body, ms});
    endtask

    // mostly records from a small body pool on an advancing clock, some queries, some noise
    task automatic random_phase(input logic [31:0] limit, input int count,
                                input logic [31:0] start_ms, input logic [31:0] max_step,
                                input bit quiet);
        logic [BODY_W-1:0] pool [BODY_POOL];
        logic [TIME_W-1:0] now_ms;
        int                pick;
        if (quiet) begin
            wait_drained;
            idling_on = 1'b0;
        end
        set_max_age(limit);
        foreach (pool[i])
            pool[i] = $urandom;
        if ($urandom_range(0, 1) == 1)
            pool[BODY_POOL-1] = '0;
        now_ms = start_ms;
        for (int k = 0; k < count; k++) begin
            pick   = $urandom_range(0, 99);
            now_ms = now_ms + $urandom_range(0, max_step);
            if (pick < 70)
                push_beacon(CMD_RECORD, pool[$urandom_range(0, BODY_POOL-1)], now_ms);
            else if (pick < 90)
                push_beacon(CMD_QUERY, $urandom, now_ms);
            else
                push_beacon(1'($urandom_range(0, 1)), $urandom, $urandom);
        end
    endtask

    initial begin
        foreach (seen_stamp[i]) begin
            seen_stamp[i] = '0;
            seen_body[i]  = '0;
        end
        age_limit = MAX_AGE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apb_access(1'b0, MAX_AGE_RESET);

        // everything aged out: nothing valid, average falls back to zero
        push_beacon(CMD_QUERY, 32'h0, 32'd40000);
        // cleared entries hold body zero, so a zero body matches entry 0
        push_beacon(CMD_RECORD, 32'h0, 32'd5);
        push_beacon(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // ties on stamp zero go to the lowest index, then every stamp ends at maximum
        for (int k = 1; k <= 9; k++)
            push_beacon(CMD_RECORD, 32'h5A00_0000 | (k * 37), 32'hFFFF_FFFF);
        push_beacon(CMD_RECORD, 32'h1234_5680, 32'd7);
        push_beacon(CMD_RECORD, 32'h5A00_0025, 32'd100);
        push_beacon(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_beacon(CMD_RECORD, 32'h0, 32'd0);
        push_beacon(CMD_RECORD, 32'h0, 32'd1);

        set_max_age(32'd0);
        push_beacon(CMD_QUERY, 32'h0, 32'hFFFF_FFFF);
        push_beacon(CMD_RECORD, 32'h7777_77FF, 32'd0);

        set_max_age(32'hFFFF_FFFF);
        push_beacon(CMD_QUERY, 32'h0, 32'd0);
        push_beacon(CMD_QUERY, 32'h0, 32'h8000_0000);

        random_phase(32'd15000, 300, $urandom, 32'd4000, 1'b0);
        random_phase(32'd0, 250, $urandom, 32'd2, 1'b0);
        random_phase(32'hFFFF_FFFF, 250, $urandom, 32'hFFFF_FFFF, 1'b0);
        random_phase($urandom, 250, $urandom, $urandom, 1'b0);
        // clock runs across the 32-bit wrap
        random_phase(32'd1000, 300, 32'hFFFF_F000, 32'd300, 1'b0);
        random_phase(MAX_AGE_RESET, 400, $urandom, 32'd8000, 1'b1);

        wait_drained;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d record and %0d query beats under %0d max_age settings",
                 records_taken, queries_taken, limits_written + 1);
        $display("%0d result beats checked, %0d mismatches", replies_seen, fault_count);
        if (fault_count == 0 && replies_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
